// ===== rtl/core/rdrr_pkg.sv =====
package rdrr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 5;
    localparam int DIV_STEPS    = 32;

    localparam logic signed [32:0] TRIG_ONE     = 33'sd1073741824;
    localparam logic signed [32:0] GAIN_INV_Q30 = 33'sd652032874;
    localparam logic [31:0]        MAX_DIST     = 32'hFFFF_FFFF;

    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef logic signed [32:0] trig_t;
    typedef logic signed [33:0] zang_t;

    typedef enum logic [2:0] {
        REG_ANCHOR_X   = 3'd0,
        REG_ANCHOR_Y   = 3'd1,
        REG_BOX_ANGLE  = 3'd2,
        REG_BOX_LENGTH = 3'd3,
        REG_BOX_WIDTH  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        trig_t x;
        trig_t y;
        zang_t z;
    } cordic_vec_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] den;
        logic [1:0]  pend;
        logic [31:0] quo;
    } div_vec_t;

    function automatic zang_t atan_turn(input logic [STEP_W-1:0] i);
        return zang_t'({2'b00, ATAN_TURN[i]});
    endfunction

endpackage

// ===== rtl/core/ray_distance_in_rotated_rectangle.sv =====
// Distance along a ray from a sensor point to the first wall of a configured
// rotated rectangle. One transaction is accepted in every cycle (busy stays
// low). Each transaction passes through 53 register stages: 16 CORDIC cells,
// four frame-rotation and wall-gap stages, 32 divider cells and the output
// register. The first stage loads at the accepting edge, and done is driven
// by the output register. The receiver cannot stall, so done is a one-cycle
// strobe that must be sampled. Configuration writes take effect at once and
// must only be made while no transaction is in flight.
module ray_distance_in_rotated_rectangle (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic [15:0]        ray_angle,
    output logic               done,
    output logic [31:0]        wall_distance,
    output logic               point_outside
);
    import rdrr_pkg::*;

    typedef struct packed {
        logic       spec;
        logic [1:0] quad;
        logic       flip;
        zang_t      z;
    } ang_prep_t;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic       bspec;
        logic [1:0] bquad;
        logic       bflip;
        logic       rspec;
        logic [1:0] rquad;
        logic       rflip;
    } side_t;

    typedef struct packed {
        logic outside;
        logic hx;
        logic hy;
        logic satx;
        logic saty;
    } flags_t;

    function automatic ang_prep_t prep(input logic [15:0] ang);
        ang_prep_t p;
        zang_t     z;
        z = zang_t'($signed({ang, 16'h0000}));
        p.spec = (ang[13:0] == 14'd0);
        p.quad = ang[15:14];
        p.flip = 1'b0;
        p.z    = z;
        if (z > zang_t'(34'sd1073741824))
        begin
            p.z    = z - zang_t'(34'sd2147483648);
            p.flip = 1'b1;
        end
        else if (z < -zang_t'(34'sd1073741824))
        begin
            p.z    = z + zang_t'(34'sd2147483648);
            p.flip = 1'b1;
        end
        return p;
    endfunction

    function automatic trig_t pick(input logic spec, input logic [1:0] quad,
                                   input logic flip, input trig_t raw,
                                   input logic is_sin);
        trig_t r;
        if (spec)
        begin
            unique case ({is_sin, quad})
                3'b000:  r = TRIG_ONE;
                3'b010:  r = -TRIG_ONE;
                3'b101:  r = TRIG_ONE;
                3'b111:  r = -TRIG_ONE;
                default: r = '0;
            endcase
        end
        else
        begin
            r = flip ? -raw : raw;
        end
        return r;
    endfunction

    logic signed [31:0] anchor_x_reg;
    logic signed [31:0] anchor_y_reg;
    logic [15:0]        box_angle_reg;
    logic [30:0]        box_length_reg;
    logic [30:0]        box_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_x_reg   <= '0;
            anchor_y_reg   <= '0;
            box_angle_reg  <= '0;
            box_length_reg <= '0;
            box_width_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ANCHOR_X:   anchor_x_reg   <= cfg_data;
                REG_ANCHOR_Y:   anchor_y_reg   <= cfg_data;
                REG_BOX_ANGLE:  box_angle_reg  <= cfg_data[15:0];
                REG_BOX_LENGTH: box_length_reg <= cfg_data[30:0];
                REG_BOX_WIDTH:  box_width_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // cordic chains for box angle and relative ray angle
    ang_prep_t   bp;
    ang_prep_t   rp;
    cordic_vec_t bcv [CORDIC_STEPS+1];
    cordic_vec_t rcv [CORDIC_STEPS+1];
    side_t       sd  [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] cv_reg;

    always_comb
    begin
        bp = prep(box_angle_reg);
        rp = prep(16'(ray_angle - box_angle_reg));
        bcv[0] = '{x: GAIN_INV_Q30, y: '0, z: bp.z};
        rcv[0] = '{x: GAIN_INV_Q30, y: '0, z: rp.z};
        sd[0].dx    = 33'(point_x) - 33'(anchor_x_reg);
        sd[0].dy    = 33'(point_y) - 33'(anchor_y_reg);
        sd[0].bspec = bp.spec;
        sd[0].bquad = bp.quad;
        sd[0].bflip = bp.flip;
        sd[0].rspec = rp.spec;
        sd[0].rquad = rp.quad;
        sd[0].rflip = rp.flip;
        cv_reg[0]   = start;
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        side_t sd_reg;

        rdrr_cordic_cell u_bcell (
            .clk  (clk),
            .vin  (bcv[k]),
            .step (STEP_W'(k)),
            .vout (bcv[k+1])
        );

        rdrr_cordic_cell u_rcell (
            .clk  (clk),
            .vin  (rcv[k]),
            .step (STEP_W'(k)),
            .vout (rcv[k+1])
        );

        always_ff @(posedge clk)
        begin
            sd_reg <= sd[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[k+1] <= 1'b0;
            else
                cv_reg[k+1] <= cv_reg[k];
        end

        assign sd[k+1] = sd_reg;
    end

    // stage a: trig selection
    trig_t              a_bc_reg, a_bs_reg, a_c_reg, a_s_reg;
    logic signed [32:0] a_dx_reg, a_dy_reg;
    // stage b: frame rotation products
    logic signed [65:0] b_p1_reg, b_p2_reg, b_p3_reg, b_p4_reg;
    trig_t              b_c_reg, b_s_reg;
    // stage c: rotated coordinates
    logic signed [36:0] c_u_reg, c_v_reg;
    trig_t              c_c_reg, c_s_reg;
    // stage d: wall gaps
    logic [32:0]        d_gx_reg, d_gy_reg;
    logic [31:0]        d_dnx_reg, d_dny_reg;
    logic               d_out_reg, d_hx_reg, d_hy_reg;
    logic [3:0]         pv_reg;

    side_t              st;
    logic signed [66:0] u_sum, v_sum;
    logic signed [36:0] u_n, v_n;
    logic signed [37:0] u_e, v2, len_s, wid_s;
    logic [32:0]        cabs, sabs;
    logic               outside_n;
    logic [32:0]        gx_n, gy_n;

    assign st = sd[CORDIC_STEPS];

    always_comb
    begin
        u_sum = 67'(b_p1_reg) + 67'(b_p2_reg);
        v_sum = 67'(b_p3_reg) - 67'(b_p4_reg);
        u_n   = u_sum[66:30];
        v_n   = v_sum[66:30];
        u_e   = 38'(c_u_reg);
        v2    = 38'(c_v_reg) <<< 1;
        len_s = $signed({7'b0, box_length_reg});
        wid_s = $signed({7'b0, box_width_reg});
        outside_n = (u_e < 0) || (u_e > len_s) || (v2 < -wid_s) || (v2 > wid_s);
        cabs = (c_c_reg < 0) ? 33'(-c_c_reg) : 33'(c_c_reg);
        sabs = (c_s_reg < 0) ? 33'(-c_s_reg) : 33'(c_s_reg);
        gx_n = (c_c_reg > 0) ? 33'(len_s - u_e) : 33'(u_e);
        gy_n = (c_s_reg > 0) ? 33'(wid_s - v2) : 33'(wid_s + v2);
    end

    always_ff @(posedge clk)
    begin
        a_bc_reg <= pick(st.bspec, st.bquad, st.bflip, bcv[CORDIC_STEPS].x, 1'b0);
        a_bs_reg <= pick(st.bspec, st.bquad, st.bflip, bcv[CORDIC_STEPS].y, 1'b1);
        a_c_reg  <= pick(st.rspec, st.rquad, st.rflip, rcv[CORDIC_STEPS].x, 1'b0);
        a_s_reg  <= pick(st.rspec, st.rquad, st.rflip, rcv[CORDIC_STEPS].y, 1'b1);
        a_dx_reg <= st.dx;
        a_dy_reg <= st.dy;

        b_p1_reg <= a_dx_reg * a_bc_reg;
        b_p2_reg <= a_dy_reg * a_bs_reg;
        b_p3_reg <= a_dy_reg * a_bc_reg;
        b_p4_reg <= a_dx_reg * a_bs_reg;
        b_c_reg  <= a_c_reg;
        b_s_reg  <= a_s_reg;

        c_u_reg <= u_n;
        c_v_reg <= v_n;
        c_c_reg <= b_c_reg;
        c_s_reg <= b_s_reg;

        d_out_reg <= outside_n;
        d_gx_reg  <= gx_n;
        d_gy_reg  <= gy_n;
        d_dnx_reg <= cabs[31:0];
        d_dny_reg <= {sabs[30:0], 1'b0};
        d_hx_reg  <= (c_c_reg != 0);
        d_hy_reg  <= (c_s_reg != 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else
            pv_reg <= {pv_reg[2:0], cv_reg[CORDIC_STEPS]};
    end

    // divider chains
    div_vec_t dvx [DIV_STEPS+1];
    div_vec_t dvy [DIV_STEPS+1];
    flags_t   fl  [DIV_STEPS+1];
    logic [DIV_STEPS:0] dv_reg;

    always_comb
    begin
        dvx[0] = '{rem: 32'(d_gx_reg >> 2), den: d_dnx_reg, pend: d_gx_reg[1:0], quo: '0};
        dvy[0] = '{rem: 32'(d_gy_reg >> 2), den: d_dny_reg, pend: d_gy_reg[1:0], quo: '0};
        fl[0].outside = d_out_reg;
        fl[0].hx      = d_hx_reg;
        fl[0].hy      = d_hy_reg;
        fl[0].satx    = ({1'b0, d_gx_reg} >= {d_dnx_reg, 2'b00});
        fl[0].saty    = ({1'b0, d_gy_reg} >= {d_dny_reg, 2'b00});
        dv_reg[0]     = pv_reg[3];
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        flags_t fl_reg;

        rdrr_div_cell u_xcell (
            .clk  (clk),
            .vin  (dvx[k]),
            .vout (dvx[k+1])
        );

        rdrr_div_cell u_ycell (
            .clk  (clk),
            .vin  (dvy[k]),
            .vout (dvy[k+1])
        );

        always_ff @(posedge clk)
        begin
            fl_reg <= fl[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else
                dv_reg[k+1] <= dv_reg[k];
        end

        assign fl[k+1] = fl_reg;
    end

    flags_t      ff;
    logic [31:0] qx, qy, best;
    logic        done_reg;
    logic [31:0] dist_reg;
    logic        outs_reg;

    always_comb
    begin
        ff = fl[DIV_STEPS];
        qx = (ff.hx && !ff.satx) ? dvx[DIV_STEPS].quo : MAX_DIST;
        qy = (ff.hy && !ff.saty) ? dvy[DIV_STEPS].quo : MAX_DIST;
        best = (qx < qy) ? qx : qy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= ff.outside ? 32'd0 : best;
        outs_reg <= ff.outside;
    end

    assign done          = done_reg;
    assign wall_distance = dist_reg;
    assign point_outside = outs_reg;

endmodule

// ===== rtl/core/rdrr_cordic_cell.sv =====
module rdrr_cordic_cell (
    input  logic                          clk,
    input  rdrr_pkg::cordic_vec_t         vin,
    input  logic [rdrr_pkg::STEP_W-1:0]   step,
    output rdrr_pkg::cordic_vec_t         vout
);
    import rdrr_pkg::*;

    cordic_vec_t v_next;
    cordic_vec_t v_reg;
    trig_t       xs;
    trig_t       ys;
    zang_t       a;

    always_comb
    begin
        xs = vin.x >>> step;
        ys = vin.y >>> step;
        a  = atan_turn(step);
        if (vin.z >= 0)
        begin
            v_next.x = vin.x - ys;
            v_next.y = vin.y + xs;
            v_next.z = vin.z - a;
        end
        else
        begin
            v_next.x = vin.x + ys;
            v_next.y = vin.y - xs;
            v_next.z = vin.z + a;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign vout = v_reg;

endmodule

// ===== rtl/core/rdrr_div_cell.sv =====
module rdrr_div_cell (
    input  logic                  clk,
    input  rdrr_pkg::div_vec_t    vin,
    output rdrr_pkg::div_vec_t    vout
);
    import rdrr_pkg::*;

    div_vec_t    v_next;
    div_vec_t    v_reg;
    logic [32:0] t;
    logic        ge;

    always_comb
    begin
        t  = {vin.rem, vin.pend[1]};
        ge = (t >= {1'b0, vin.den});
        v_next.rem  = ge ? 32'(t - {1'b0, vin.den}) : t[31:0];
        v_next.den  = vin.den;
        v_next.pend = {vin.pend[0], 1'b0};
        v_next.quo  = {vin.quo[30:0], ge};
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign vout = v_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rdrr_pkg::*;

    typedef struct {
        logic [31:0] wall_dist;
        logic        outside;
    } ray_result_t;

    class ray_scoreboard;
        longint      anc_x, anc_y, len, wid;
        logic [15:0] ang;
        ray_result_t pending[$];
        int          mismatches, checked, outside_seen;

        function new();
            anc_x = 0; anc_y = 0; len = 0; wid = 0; ang = 0;
            mismatches = 0; checked = 0; outside_seen = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [31:0] data);
            case (idx)
                REG_ANCHOR_X:   anc_x = longint'(signed'(data));
                REG_ANCHOR_Y:   anc_y = longint'(signed'(data));
                REG_BOX_ANGLE:  ang = data[15:0];
                REG_BOX_LENGTH: len = longint'(data[30:0]);
                REG_BOX_WIDTH:  wid = longint'(data[30:0]);
                default: ;
            endcase
        endfunction

        function void sin_cos(input logic [15:0] a, output longint c, output longint s);
            longint x, y, z, nx;
            bit flip;
            flip = 0;
            if (a[13:0] == 0) begin
                case (a[15:14])
                    2'd0: begin c = 64'sd1 <<< 30; s = 0; end
                    2'd1: begin c = 0; s = 64'sd1 <<< 30; end
                    2'd2: begin c = -(64'sd1 <<< 30); s = 0; end
                    default: begin c = 0; s = -(64'sd1 <<< 30); end
                endcase
                return;
            end
            z = longint'(signed'({a, 16'h0000}));
            if (z > (64'sd1 <<< 30)) begin
                z -= 64'sd1 <<< 31;
                flip = 1;
            end
            else if (z < -(64'sd1 <<< 30)) begin
                z += 64'sd1 <<< 31;
                flip = 1;
            end
            x = longint'(GAIN_INV_Q30);
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= longint'(ATAN_TURN[i]);
                end
                else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += longint'(ATAN_TURN[i]);
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint unsigned wall_time(longint unsigned gap, longint unsigned den);
            longint unsigned q;
            if (den == 0)
                return 64'hFFFF_FFFF;
            q = (gap << 30) / den;
            return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
        endfunction

        function void note_query(logic [31:0] px, logic [31:0] py, logic [15:0] ra);
            longint dx, dy, bc, bs, c, s, u, v;
            longint unsigned best, d;
            ray_result_t r;
            dx = longint'(signed'(px)) - anc_x;
            dy = longint'(signed'(py)) - anc_y;
            sin_cos(ang, bc, bs);
            u = (dx * bc + dy * bs) >>> 30;
            v = (dy * bc - dx * bs) >>> 30;
            if (u < 0 || u > len || 2 * v < -wid || 2 * v > wid) begin
                r.wall_dist = 0;
                r.outside = 1;
            end
            else begin
                best = 64'hFFFF_FFFF;
                sin_cos(ra - ang, c, s);
                if (c > 0) d = wall_time(len - u, c);
                else if (c < 0) d = wall_time(u, -c);
                else d = best;
                if (d < best) best = d;
                if (s > 0) d = wall_time(wid - 2 * v, 2 * s);
                else if (s < 0) d = wall_time(wid + 2 * v, -2 * s);
                else d = best;
                if (d < best) best = d;
                r.wall_dist = best[31:0];
                r.outside = 0;
            end
            pending = {pending, r};
        endfunction

        function void check_result(logic [31:0] got_dist, logic outside);
            ray_result_t e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: dist=%h outside=%b", got_dist, outside);
                return;
            end
            e = pending.pop_front();
            if (outside) outside_seen++;
            if (got_dist !== e.wall_dist || outside !== e.outside) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected dist=%h outside=%b, got dist=%h outside=%b",
                             e.wall_dist, e.outside, got_dist, outside);
            end
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_we = 0;
    logic [2:0]         cfg_index = 0;
    logic [31:0]        cfg_data = 0;
    logic               start = 0;
    logic               busy;
    logic signed [31:0] point_x = 0;
    logic signed [31:0] point_y = 0;
    logic [15:0]        ray_angle = 0;
    logic               done;
    logic [31:0]        wall_distance;
    logic               point_outside;

    ray_scoreboard sb = new();
    int            n_sent = 0;
    int            n_cfg = 0;
    int            sender_idle = 0;

    ray_distance_in_rotated_rectangle dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .point_x(point_x),
        .point_y(point_y), .ray_angle(ray_angle), .done(done),
        .wall_distance(wall_distance), .point_outside(point_outside)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_we)
                sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
            if (start && !busy)
                sb.note_query(point_x, point_y, ray_angle);
            if (done)
                sb.check_result(wall_distance, point_outside);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 0;
        n_cfg++;
    endtask

    task automatic drain();
        @(negedge clk);
        start = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_query(logic [31:0] px, logic [31:0] py, logic [15:0] ra);
        while ($urandom_range(99) < sender_idle) begin
            @(negedge clk);
            start = 0;
        end
        @(negedge clk);
        start = 1;
        point_x = px;
        point_y = py;
        ray_angle = ra;
        do @(posedge clk); while (busy);
        n_sent++;
    endtask

    task automatic set_box(logic [31:0] ax, logic [31:0] ay, logic [15:0] a,
                           logic [30:0] l, logic [30:0] w);
        write_reg(REG_ANCHOR_X, ax);
        write_reg(REG_ANCHOR_Y, ay);
        write_reg(REG_BOX_ANGLE, {16'h0, a});
        write_reg(REG_BOX_LENGTH, {1'b0, l});
        write_reg(REG_BOX_WIDTH, {1'b0, w});
    endtask

    // mostly points built inside the box, some anywhere
    task automatic send_random();
        longint u, v, c, s, px, py;
        logic [15:0] ra;
        ra = ($urandom_range(7) == 0) ? 16'($urandom_range(3) << 14) : 16'($urandom);
        if ($urandom_range(9) < 7) begin
            u = longint'($urandom_range(0, 32'(sb.len)));
            v = longint'($urandom_range(0, 32'(sb.wid))) - sb.wid / 2;
            if ($urandom_range(15) == 0) u = ($urandom_range(1)) ? sb.len : 0;
            sb.sin_cos(sb.ang, c, s);
            px = sb.anc_x + ((u * c - v * s) >>> 30);
            py = sb.anc_y + ((u * s + v * c) >>> 30);
            send_query(px[31:0], py[31:0], ra);
        end
        else
            send_query($urandom, $urandom, ra);
    endtask

    initial
    begin
        int seg_idle[3];
        seg_idle = '{12, 57, 0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // degenerate box at reset values
        send_query(0, 0, 16'h0000);
        send_query(0, 0, 16'h4000);
        send_query(0, 0, 16'h8000);
        send_query(0, 0, 16'hC000);
        send_query(0, 0, 16'h2000);
        send_query(32'h0001_0000, 0, 16'h1234);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 16'h0001);
        drain();

        set_box(0, 0, 16'h0000, 31'd100 << 16, 31'd40 << 16);
        send_query(0, 0, 16'h0000);
        send_query(32'd100 << 16, 0, 16'h8000);
        send_query(0, 32'd20 << 16, 16'hC000);
        send_query(32'd100 << 16, -(32'd20 << 16), 16'h4000);
        send_query(32'd50 << 16, 0, 16'h0000);
        send_query(32'd50 << 16, 0, 16'h4000);
        send_query(32'd50 << 16, 0, 16'h8000);
        send_query(32'd50 << 16, 0, 16'hC000);
        send_query(32'd50 << 16, 0, 16'h2000);
        send_query(-1, 0, 16'h0000);
        send_query((32'd100 << 16) + 1, 0, 16'h0000);
        send_query(32'd50 << 16, (32'd20 << 16) + 1, 16'h0000);
        send_query(32'd50 << 16, 32'd5 << 16, 16'h3FFF);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            sender_idle = seg_idle[ph / 2];
            case (ph)
                0: set_box($urandom_range(0, 1 << 24) - (1 << 23),
                           $urandom_range(0, 1 << 24) - (1 << 23),
                           16'($urandom), 31'($urandom_range(1, 1 << 24)),
                           31'($urandom_range(1, 1 << 24)));
                1: set_box(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
                2: set_box($urandom, $urandom, 16'h4000, 31'($urandom_range(0, 1 << 26)), 0);
                3: set_box(32'h7FFF_FFFF, 32'h8000_0000, 16'h0001, 0,
                           31'($urandom_range(0, 1 << 26)));
                4: set_box($urandom, $urandom, 16'($urandom), 31'($urandom), 31'($urandom));
                default: set_box(0, 0, 16'hC000, 31'h7FFF_FFFF, 31'd1 << 16);
            endcase
            for (int i = 0; i < 150; i++)
                send_random();
            drain();
        end

        $display("%0d transactions over %0d register writes, reset box and 7 written boxes, %0d outside",
                 n_sent, n_cfg, sb.outside_seen);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("** ray_distance_in_rotated_rectangle: PASSED **");
        else
            $display("** ray_distance_in_rotated_rectangle: FAILED **");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("** ray_distance_in_rotated_rectangle: FAILED **");
        $finish;
    end

endmodule
